### rtl/sabs_pkg.sv
package sabs_pkg;

  // Table geometry
  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  // Signed search bounds: room for -1 and for DEPTH
  localparam int PTR_W  = ADDR_W + 2;

  localparam logic signed [PTR_W-1:0] HI_MAX = PTR_W'(DEPTH - 1);

  // Commands from controller to datapath
  typedef struct packed {
    logic wr;        // store one table entry
    logic load;      // latch a new search
    logic probe_rd;  // read the entry at the midpoint
    logic probe_upd; // act on the midpoint compare
    logic back_rd;   // read the entry below first
    logic back_upd;  // step first down by one
    logic finish;    // register the result fields
  } sabs_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;      // lo > hi
    logic eq;         // read word equals target
    logic first_zero; // backward walk reached index zero
  } sabs_stat_t;

endpackage

### rtl/sabs_ctrl.sv
module sabs_ctrl
  import sabs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       action,
  input  sabs_stat_t stat,
  output sabs_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PROBE_ADR = 3'd1;
  localparam logic [2:0] S_PROBE_CMP = 3'd2;
  localparam logic [2:0] S_BACK_ADR  = 3'd3;
  localparam logic [2:0] S_BACK_CMP  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign accept = start && (state == S_IDLE);
  assign busy   = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept && !action) begin
          cmd.wr = 1'b1;
        end else if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_PROBE_ADR;
        end
      end
      S_PROBE_ADR: begin
        if (stat.empty) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.probe_rd = 1'b1;
          state_next   = S_PROBE_CMP;
        end
      end
      S_PROBE_CMP: begin
        cmd.probe_upd = 1'b1;
        state_next    = stat.eq ? S_BACK_ADR : S_PROBE_ADR;
      end
      S_BACK_ADR: begin
        if (stat.first_zero) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.back_rd = 1'b1;
          state_next  = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (stat.eq) begin
          cmd.back_upd = 1'b1;
          state_next   = S_BACK_ADR;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

`ifndef SYNTHESIS
  // A result beat follows a busy cycle and lands back in idle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a search in progress");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && action) |=> busy)
    else $error("search accepted but controller not busy");

  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !action) |=> (!busy && !done))
    else $error("table write started a search");
`endif

endmodule

### rtl/sabs_dp.sv
module sabs_dp
  import sabs_pkg::*;
(
  input  logic                clk,
  input  sabs_cmd_t           cmd,
  input  logic [9:0]          entry_index,
  input  logic signed [31:0]  entry_value,
  input  logic [9:0]          search_low,
  input  logic signed [10:0]  search_high,
  input  logic signed [31:0]  target,
  output sabs_stat_t          stat,
  output logic                found,
  output logic [9:0]          match_index,
  output logic [10:0]         insert_index,
  output logic [9:0]          first_index
);

  logic signed [31:0]      mem [DEPTH];
  logic signed [31:0]      rdata;
  logic signed [31:0]      tgt;
  logic signed [PTR_W-1:0] lo;
  logic signed [PTR_W-1:0] hi;
  logic signed [PTR_W-1:0] hi_in;
  logic signed [PTR_W-1:0] diff;
  logic signed [PTR_W-1:0] mid_w;
  logic [ADDR_W-1:0]       mid;
  logic [ADDR_W-1:0]       first;
  logic [ADDR_W-1:0]       rd_addr;
  logic                    hit;
  logic                    wr_ok;

  // Midpoint rounded toward the low end
  assign diff  = hi - lo;
  assign mid_w = lo + (diff >>> 1);

  assign hi_in = (PTR_W'(search_high) > HI_MAX) ? HI_MAX : PTR_W'(search_high);
  assign wr_ok = ({1'b0, entry_index} < 11'(DEPTH));

  assign stat.empty      = (lo > hi);
  assign stat.eq         = (rdata == tgt);
  assign stat.first_zero = (first == '0);

  assign rd_addr = cmd.probe_rd ? mid_w[ADDR_W-1:0] : (first - 1'b1);

  // Table storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      mem[entry_index[ADDR_W-1:0]] <= entry_value;
    end
    if (cmd.probe_rd || cmd.back_rd) begin
      rdata <= mem[rd_addr];
    end
  end

  // Search bounds and hit tracking
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo  <= PTR_W'(search_low);
      hi  <= hi_in;
      tgt <= target;
      hit <= 1'b0;
    end
    if (cmd.probe_rd) begin
      mid <= mid_w[ADDR_W-1:0];
    end
    if (cmd.probe_upd) begin
      if (rdata == tgt) begin
        hit   <= 1'b1;
        first <= mid;
      end else if (rdata < tgt) begin
        lo <= $signed({2'b00, mid}) + PTR_W'(1);
      end else begin
        hi <= $signed({2'b00, mid}) - PTR_W'(1);
      end
    end
    if (cmd.back_upd) begin
      first <= first - 1'b1;
    end
  end

  // Result fields; a miss reports the lower bound held in lo
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found        <= hit;
      match_index  <= hit ? 10'(mid) : 10'd0;
      insert_index <= hit ? 11'(mid) : lo[10:0];
      first_index  <= hit ? 10'(first) : 10'd0;
    end
  end

endmodule

### rtl/sorted_array_binary_search.sv
// Sorted table search.
// Holds 1024 signed 32-bit entries, which the user must keep ascending; the block does not enforce it.
// Input: one beat is taken when start is high and busy is low.
//   action = 0 writes entry_value at entry_index; no result follows and
//   busy stays low, so the next beat may come in the next cycle.
//   action = 1 searches [search_low, search_high] for target.
// Output: each search gives one result beat, done high for one cycle with
//   found, match_index, insert_index and first_index. The receiver has no
//   way to stall; the fields hold until the next result.
// Search: a miss finishes when the range runs empty, after at most 11
//   midpoint probes. A hit then steps backward over equal entries and
//   finishes when the entry below differs or the walk reaches index zero.
//   Each probe or step issues the table read (registered read port) in
//   one state and compares in the next. A new beat is taken in the cycle
//   done is high.
// Reset clears the controller only; table contents stay undefined until
//   written.
module sorted_array_binary_search
  import sabs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [9:0]         entry_index,
  input  logic signed [31:0] entry_value,
  input  logic [9:0]         search_low,
  input  logic signed [10:0] search_high,
  input  logic signed [31:0] target,
  output logic               done,
  output logic               found,
  output logic [9:0]         match_index,
  output logic [10:0]        insert_index,
  output logic [9:0]         first_index
);

  sabs_cmd_t  cmd;
  sabs_stat_t stat;

  sabs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  sabs_dp u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_low   (search_low),
    .search_high  (search_high),
    .target       (target),
    .stat         (stat),
    .found        (found),
    .match_index  (match_index),
    .insert_index (insert_index),
    .first_index  (first_index)
  );

endmodule

### bench/sorted_array_binary_search_tb.sv
`timescale 1ns / 1ps

module sorted_array_binary_search_tb;
  import sabs_pkg::*;

  localparam logic WRITE_OP  = 1'b0;
  localparam logic SEARCH_OP = 1'b1;

  localparam logic [31:0] WORD_MIN = 32'h8000_0000;
  localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

  // Searches read the loaded low part, except directed ones at entries 1022 and 1023
  localparam int          FILL_N   = 160;
  localparam logic [10:0] FILL_TOP = 11'(FILL_N - 1);

  localparam int RANDOM_BEATS = 250;
  localparam int TAIL_CYCLES  = 40;
  localparam int MAX_RUN      = 48;

  // Result fields of one search
  typedef struct packed {
    logic        fnd;
    logic [9:0]  mi;
    logic [10:0] ii;
    logic [9:0]  fi;
  } search_res_t;

  // One input beat plus an optional hand-typed result
  typedef struct packed {
    logic        act;
    logic [9:0]  widx;
    logic [31:0] wval;
    logic [9:0]  lo;
    logic [10:0] hi;
    logic [31:0] tgt;
    logic        known;
    search_res_t res;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               action;
  logic [9:0]         entry_index;
  logic signed [31:0] entry_value;
  logic [9:0]         search_low;
  logic signed [10:0] search_high;
  logic signed [31:0] target;
  logic               done;
  logic               found;
  logic [9:0]         match_index;
  logic [10:0]        insert_index;
  logic [9:0]         first_index;

  // Typed result travels with the beat it belongs to
  logic               beat_known;
  search_res_t        beat_res;

  // Table as the block sees it (accepted writes) and as the driver plans it
  logic signed [31:0] table_copy [0:DEPTH-1];
  logic signed [31:0] planned    [0:DEPTH-1];

  search_res_t        pending_results [$];
  search_res_t        want;
  bit                 idle_on;
  int                 mismatches = 0;
  int                 writes_seen = 0;
  int                 searches_seen = 0;
  int                 hits_seen = 0;
  int                 deepest_walk = 0;

  sorted_array_binary_search u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .search_low   (search_low),
    .search_high  (search_high),
    .target       (target),
    .done         (done),
    .found        (found),
    .match_index  (match_index),
    .insert_index (insert_index),
    .first_index  (first_index)
  );

  always #4 clk = ~clk;

  initial begin
    #40_000_000;
    $display("FAIL sorted_array_binary_search");
    $finish;
  end

  // Halving search, then backward walk over equal entries or lower bound
  function automatic search_res_t predict_search(input logic [9:0] lo_in,
                                                 input logic signed [10:0] hi_in,
                                                 input logic signed [31:0] tgt);
    int lo, hi, mid, top, walk;
    search_res_t r;
    r = '0;
    top = hi_in;
    if (top > DEPTH - 1) top = DEPTH - 1;
    lo = lo_in;
    hi = top;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] == tgt) begin
        r.fnd = 1'b1;
        r.mi  = 10'(mid);
        break;
      end else if (tgt < table_copy[mid]) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (r.fnd) begin
      r.ii = 11'(r.mi);
      walk = r.mi;
      // walk is not bounded by the searched range
      while (walk > 0 && table_copy[walk-1] == tgt) walk--;
      r.fi = 10'(walk);
      if (r.mi - walk > deepest_walk) deepest_walk = r.mi - walk;
    end else begin
      lo = lo_in;
      hi = top;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (table_copy[mid] < tgt) lo = mid + 1;
        else hi = mid - 1;
      end
      r.ii = 11'(lo);
    end
    return r;
  endfunction

  function automatic beat_t write_beat(input logic [9:0] idx, input logic [31:0] val);
    beat_t b;
    b = '0;
    b.act  = WRITE_OP;
    b.widx = idx;
    b.wval = val;
    return b;
  endfunction

  function automatic beat_t search_beat(input logic [9:0] lo, input logic [10:0] hi,
                                        input logic [31:0] tgt);
    beat_t b;
    b = '0;
    b.act = SEARCH_OP;
    b.lo  = lo;
    b.hi  = hi;
    b.tgt = tgt;
    return b;
  endfunction

  function automatic beat_t known_beat(input logic [9:0] lo, input logic [10:0] hi,
                                       input logic [31:0] tgt, input logic f,
                                       input logic [9:0] m, input logic [10:0] ins,
                                       input logic [9:0] fi);
    beat_t b;
    b = search_beat(lo, hi, tgt);
    b.known = 1'b1;
    b.res   = '{f, m, ins, fi};
    return b;
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic issue_beat(input beat_t b);
    while (idle_on && $urandom_range(0, 99) < 30) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    action      <= b.act;
    entry_index <= b.widx;
    entry_value <= b.wval;
    search_low  <= b.lo;
    search_high <= b.hi;
    target      <= b.tgt;
    beat_known  <= b.known;
    beat_res    <= b.res;
    if (b.act == WRITE_OP) planned[b.widx] = b.wval;
    // busy only moves at the rising edge, so its value here decides the next edge
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // Load the low part of the table in ascending order: a step ladder, or long equal runs
  task automatic fill_table(input bit long_runs);
    longint v;
    int     i, run, run_len;
    beat_t  b;
    v = -64'sd2147483648;
    run = 0;
    run_len = 1;
    for (i = 0; i < FILL_N; i++) begin
      if (!long_runs) begin
        if (i == 0) v = -64'sd2147483648;
        else if (i == FILL_N - 1) v = 64'sd2147483647;
        else v = (i / 2) * 8 - 2040;
      end else if (i == 0) begin
        run_len = $urandom_range(1, MAX_RUN);
        run = 1;
      end else if (i == FILL_N - 1) begin
        v = 64'sd2147483647;
      end else if (run >= run_len) begin
        v += $urandom_range(1, 1 << 21);
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, MAX_RUN)
                                               : $urandom_range(1, 4);
        run = 1;
      end else begin
        run++;
      end
      b        = write_beat(10'(i), 32'(v));
      b.lo     = 10'($urandom);
      b.hi     = 11'($urandom);
      b.tgt    = $urandom;
      issue_beat(b);
    end
  endtask

  // Track accepted beats and check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no search pending");
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          searches_seen++;
          if (found) hits_seen++;
          if (found !== want.fnd) begin
            $error("found: expected %0d, got %0d", want.fnd, found);
            mismatches++;
          end
          if (match_index !== want.mi) begin
            $error("match_index: expected %0d, got %0d", want.mi, match_index);
            mismatches++;
          end
          if (insert_index !== want.ii) begin
            $error("insert_index: expected %0d, got %0d", want.ii, insert_index);
            mismatches++;
          end
          if (first_index !== want.fi) begin
            $error("first_index: expected %0d, got %0d", want.fi, first_index);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        if (action == WRITE_OP) begin
          table_copy[entry_index] = entry_value;
          writes_seen++;
        end else if (beat_known) begin
          pending_results.push_back(beat_res);
        end else begin
          pending_results.push_back(predict_search(search_low, search_high, target));
        end
      end
    end
  end

  initial begin
    beat_t  b;
    beat_t  directed [$];
    int     n, r, lo_i, idx_i;
    longint low_v, up_v, span;

    rst         <= 1'b1;
    start       <= 1'b0;
    action      <= WRITE_OP;
    entry_index <= '0;
    entry_value <= '0;
    search_low  <= '0;
    search_high <= '0;
    target      <= '0;
    beat_known  <= 1'b0;
    beat_res    <= '0;
    idle_on = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Ladder: INT_MIN at 0, INT_MAX at the top of the loaded part, equal pairs between
    fill_table(1'b0);
    idle_on = 1'b1;

    // Directed beats over the ladder
    directed.push_back(known_beat(10'd5, 11'h7FF, 32'd0, 1'b0, 10'd0, 11'd5, 10'd0));
    directed.push_back(known_beat(10'd1023, 11'h400, 32'd0, 1'b0, 10'd0, 11'd1023, 10'd0));
    directed.push_back(known_beat(10'd1023, 11'd1022, WORD_MAX, 1'b0, 10'd0, 11'd1023,
                                  10'd0));
    directed.push_back(known_beat(10'd0, 11'd0, WORD_MIN, 1'b1, 10'd0, 11'd0, 10'd0));
    directed.push_back(known_beat(10'd0, 11'd0, 32'h8000_0001, 1'b0, 10'd0, 11'd1, 10'd0));
    directed.push_back(known_beat(10'(FILL_TOP), FILL_TOP, WORD_MAX, 1'b1, 10'(FILL_TOP),
                                  FILL_TOP, 10'(FILL_TOP)));
    directed.push_back(known_beat(10'd5, 11'd10, WORD_MIN, 1'b0, 10'd0, 11'd5, 10'd0));
    // hit at 3, equal entry at 2 lies below the range
    directed.push_back(known_beat(10'd3, 11'd3, -32'sd2032, 1'b1, 10'd3, 11'd3, 10'd2));
    directed.push_back(known_beat(10'd140, 11'd158, 32'd3000, 1'b0, 10'd0, FILL_TOP,
                                  10'd0));
    directed.push_back(search_beat(10'd0, FILL_TOP, 32'd0));
    directed.push_back(search_beat(10'd0, FILL_TOP, WORD_MAX));
    directed.push_back(search_beat(10'd0, FILL_TOP, WORD_MIN));
    directed.push_back(search_beat(10'd0, FILL_TOP, 32'd1));
    // top two entries of the table: insertion point past the table
    directed.push_back(write_beat(10'd1022, 32'd4000));
    directed.push_back(write_beat(10'd1023, 32'd5000));
    directed.push_back(known_beat(10'd1023, 11'd1023, 32'd6000, 1'b0, 10'd0, 11'd1024,
                                  10'd0));
    directed.push_back(known_beat(10'd1022, 11'd1023, WORD_MAX, 1'b0, 10'd0, 11'd1024,
                                  10'd0));
    directed.push_back(known_beat(10'd1022, 11'd1023, 32'd5000, 1'b1, 10'd1023, 11'd1023,
                                  10'd1023));
    directed.push_back(write_beat(10'd0, -32'sd5000));
    directed.push_back(known_beat(10'd0, FILL_TOP, WORD_MIN, 1'b0, 10'd0, 11'd0, 10'd0));
    directed.push_back(search_beat(10'd0, FILL_TOP, -32'sd5000));
    // unsorted table: a spike in the middle, then put back
    directed.push_back(write_beat(10'd80, WORD_MAX));
    directed.push_back(search_beat(10'd0, FILL_TOP, 32'd4000));
    directed.push_back(search_beat(10'd0, FILL_TOP, WORD_MAX));
    directed.push_back(write_beat(10'd80, -32'sd1720));
    directed.push_back(search_beat(10'd0, FILL_TOP, -32'sd1720));
    foreach (directed[k]) issue_beat(directed[k]);

    // Random beats: mostly searches on a sorted table, reads kept in the loaded part
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n == RANDOM_BEATS / 2) fill_table(1'b1);
      idle_on = !(n >= 60 && n < 120);
      b        = '0;
      b.widx   = 10'($urandom);
      b.wval   = $urandom;
      b.lo     = 10'($urandom);
      b.hi     = 11'($urandom);
      b.tgt    = $urandom;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        b.act = WRITE_OP;
        idx_i = $urandom_range(0, FILL_N - 1);
        b.widx = 10'(idx_i);
        // near the end some writes break the ordering
        if (!(n >= RANDOM_BEATS - 60 && $urandom_range(0, 99) < 30)) begin
          low_v = (idx_i == 0) ? -64'sd2147483648 : longint'(planned[idx_i-1]);
          up_v  = (idx_i == FILL_N - 1) ? 64'sd2147483647 : longint'(planned[idx_i+1]);
          span  = up_v - low_v;
          if (span < 0) b.wval = 32'(low_v);
          else b.wval = 32'(low_v + longint'($urandom) % (span + 1));
        end
      end else begin
        b.act = SEARCH_OP;
        r = $urandom_range(0, 99);
        if (r < 40) lo_i = $urandom_range(0, 15);
        else if (r < 75) lo_i = $urandom_range(0, FILL_N - 1);
        else lo_i = $urandom_range(0, DEPTH - 1);
        b.lo = 10'(lo_i);
        if (r < 40) b.hi = 11'($urandom_range(FILL_N - 16, FILL_N - 1));
        else if (r < 75) b.hi = 11'($urandom_range(lo_i, FILL_N - 1));
        else if (r < 85) b.hi = 11'(lo_i - 1);
        // empty range with a random, possibly negative, top
        else b.hi = 11'(lo_i - 1 - $urandom_range(0, DEPTH - 1));
        r = $urandom_range(0, 99);
        if (r < 60) b.tgt = planned[$urandom_range(0, FILL_N - 1)];
        else if (r < 75) b.tgt = planned[$urandom_range(0, FILL_N - 1)] +
                                 (($urandom_range(0, 1) == 1) ? 32'd1 : -32'sd1);
      end
      issue_beat(b);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d table writes and %0d searches, %0d of them hits.",
             writes_seen, searches_seen, hits_seen);
    $display("Longest backward walk over equal entries: %0d steps.", deepest_walk);
    if (mismatches == 0) begin
      $display("PASS sorted_array_binary_search");
    end else begin
      $display("FAIL sorted_array_binary_search");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/sabs_pkg.sv
rtl/sabs_ctrl.sv
rtl/sabs_dp.sv
rtl/sorted_array_binary_search.sv
bench/sorted_array_binary_search_tb.sv
